[rtl/core/dae_pkg.sv]
// Shared types and constants for the DNS answer-section A-record extractor.
// Holds the request and response word layouts, the walk sequencer states and
// the protocol constants. Depends on nothing.
package dae_pkg;

   // One request word: either a packet-store load or a walk start.
   typedef struct packed {
      logic        kind;
      logic [8:0]  load_address;
      logic [7:0]  load_byte;
      logic [8:0]  start_offset;
      logic [15:0] answer_count;
      logic [9:0]  response_length;
   } dae_req_type;

   // One response word: an IPv4 record hit or the closing summary.
   typedef struct packed {
      logic        result_kind;
      logic [31:0] ipv4_address;
      logic [31:0] time_to_live;
      logic [15:0] record_number;
      logic        found_any;
      logic        malformed;
      logic        last;
   } dae_rsp_type;

   // Request kinds.
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_START = 1'b1;

   // Response kinds.
   localparam logic RESULT_ADDR    = 1'b0;
   localparam logic RESULT_SUMMARY = 1'b1;

   // A label length byte with both top bits set is a compression pointer.
   localparam logic [7:0] POINTER_MASK = 8'hC0;

   // Resource record constants.
   localparam logic [15:0] RR_TYPE_A   = 16'd1;
   localparam logic [15:0] RR_CLASS_IN = 16'd1;
   localparam logic [15:0] IPV4_LEN    = 16'd4;

   // Byte counter within a record: fixed fields are bytes 0..9 after the
   // owner name, the address is bytes 10..13.
   localparam int           BYTE_CNT_W  = 4;
   localparam logic [3:0]   FIELD_LAST  = 4'd9;
   localparam logic [3:0]   ADDR_LAST   = 4'd13;
   localparam logic [3:0]   FIELD_BYTES = 4'd10;

   // Cursor addend: a data length plus the fixed field bytes.
   localparam int ADDEND_W = 17;

   // Limit on address results per start word.
   localparam int          HIT_CNT_W        = 6;
   localparam logic [5:0]  MAX_ADDR_RESULTS = 6'd34;

   typedef enum logic [3:0] {
      W_IDLE,
      W_REC,
      W_NAME_ISSUE,
      W_NAME_USE,
      W_PTR,
      W_PTR_STEP,
      W_FLD_ISSUE,
      W_FLD_USE,
      W_ADR_ISSUE,
      W_ADR_USE,
      W_HIT,
      W_SKIP,
      W_SUM
   } walk_state_type;

endpackage

[rtl/core/dns_answer_a_record_extract.sv]
// Top level of the DNS answer-section A-record extractor; depends on dae_pkg
// and instantiates dae_store and dae_walker.
//
// Load words write one response byte each into the packet store; a load
// address at or beyond PACKET_BYTES is dropped. A start word then walks
// answer_count records from start_offset, and the block stays not ready
// until the walk has handed its last word to the output register. Every store
// byte the walk reads takes an address issue through the shared cursor adder,
// then a use of the registered read data from the single store read port; the
// second byte of a name that is a compression pointer is only checked against
// the length and then stepped over, each record adds bookkeeping in W_REC and
// W_SKIP, and each result word is held in W_HIT until the output register
// takes it.
// A record of type A, class IN and data length four produces one word with
// the address and TTL, at most 34 of them per start word; the walk always
// closes with a summary word marked last. Any read at or beyond the smaller of
// response_length and PACKET_BYTES stops the walk and sets malformed in the
// summary. Data of other records is skipped without reading it. The result
// word sits in its own register, so the next load or start word is taken
// while a finished summary still waits for rsp_ready. The store needs no
// clearing after reset: only bytes the user loaded are meant to be read.
module dns_answer_a_record_extract #(
   parameter int PACKET_BYTES = 512
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  dae_pkg::dae_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dae_pkg::dae_rsp_type rsp_data
);
   import dae_pkg::*;

   localparam int AW     = $clog2(PACKET_BYTES);
   // Room for the last readable position plus a full data length and the
   // fixed fields, which is as far as the walk position ever runs.
   localparam int POS_W  = $clog2(PACKET_BYTES + 65536 + 16);
   localparam int ULEN_W = $clog2(PACKET_BYTES + 1);

   logic          req_take;
   logic          load_en;
   logic          start;
   logic          walk_idle;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;
   logic          emit_valid;
   logic          emit_ready;
   dae_rsp_type   emit_data;

   logic        rsp_valid_ff, rsp_valid_in;
   dae_rsp_type rsp_data_ff, rsp_data_in;

   assign req_ready = walk_idle;
   assign req_take  = req_valid && req_ready;
   assign start     = req_take && (req_data.kind == KIND_START);
   // Loads outside the store are ignored.
   assign load_en   = req_take && (req_data.kind == KIND_LOAD) &&
                      (int'(req_data.load_address) < PACKET_BYTES);

   dae_store #(
      .DEPTH (PACKET_BYTES),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr (AW'(req_data.load_address)),
      .wr_data (req_data.load_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dae_walker #(
      .PACKET_BYTES (PACKET_BYTES),
      .AW           (AW),
      .POS_W        (POS_W),
      .ULEN_W       (ULEN_W)
   ) u_walker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .start_offset    (req_data.start_offset),
      .answer_count    (req_data.answer_count),
      .response_length (req_data.response_length),
      .idle            (walk_idle),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .emit_valid      (emit_valid),
      .emit_ready      (emit_ready),
      .emit_data       (emit_data)
   );

   // The output register takes a new word whenever it is empty or its
   // current word leaves in the same cycle.
   assign emit_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_valid && emit_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/core/dae_store.sv]
// Packet store: one write port for loads, one registered read port for the walk.
// Standalone module with no package dependency.
module dae_store #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] store_ff [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/dae_cursor.sv]
// Shared cursor unit: adds an addend to the walk position and checks the sum
// against the usable response length. Uses dae_pkg for the addend width.
module dae_cursor #(
   parameter int POS_W = 17
) (
   input  logic [POS_W-1:0]             base,
   input  logic [dae_pkg::ADDEND_W-1:0] addend,
   input  logic [POS_W-1:0]             limit,
   output logic [POS_W-1:0]             sum,
   output logic                         beyond
);
   import dae_pkg::*;

   assign sum    = base + POS_W'(addend);
   assign beyond = (sum >= limit);

endmodule

[rtl/core/dae_walker.sv]
// Answer-section walk sequencer: steps through names, fixed fields and
// addresses one store byte at a time through the shared cursor unit.
// Depends on dae_pkg and instantiates dae_cursor.
module dae_walker #(
   parameter int PACKET_BYTES = 512,
   parameter int AW           = 9,
   parameter int POS_W        = 17,
   parameter int ULEN_W       = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [8:0]           start_offset,
   input  logic [15:0]          answer_count,
   input  logic [9:0]           response_length,
   output logic                 idle,
   output logic [AW-1:0]        rd_addr,
   input  logic [7:0]           rd_data,
   output logic                 emit_valid,
   input  logic                 emit_ready,
   output dae_pkg::dae_rsp_type emit_data
);
   import dae_pkg::*;

   walk_state_type state_ff, state_in;

   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [ULEN_W-1:0]     ulen_ff, ulen_in;
   logic [15:0]           left_ff, left_in;
   logic [15:0]           done_ff, done_in;
   logic [HIT_CNT_W-1:0]  hits_ff, hits_in;
   logic                  found_ff, found_in;
   logic                  bad_ff, bad_in;
   logic [BYTE_CNT_W-1:0] cnt_ff, cnt_in;
   logic [79:0]           fld_ff, fld_in;
   logic [31:0]           addr_ff, addr_in;

   logic [ADDEND_W-1:0] addend;
   logic [POS_W-1:0]    sum;
   logic                beyond;
   logic                pointer;
   logic [79:0]         fld_next;
   logic                rec_match;
   logic                hit_room;
   logic [POS_W-1:0]    resp_ext;
   logic [POS_W-1:0]    store_len;

   dae_cursor #(.POS_W(POS_W)) u_cursor (
      .base   (pos_ff),
      .addend (addend),
      .limit  (POS_W'(ulen_ff)),
      .sum    (sum),
      .beyond (beyond)
   );

   assign pointer   = ((rd_data & POINTER_MASK) == POINTER_MASK);
   assign fld_next  = {fld_ff[71:0], rd_data};
   assign rec_match = (fld_next[79:64] == RR_TYPE_A) && (fld_next[63:48] == RR_CLASS_IN) &&
                      (fld_next[15:0] == IPV4_LEN);
   assign hit_room  = (hits_ff < MAX_ADDR_RESULTS);
   assign resp_ext  = POS_W'(response_length);
   assign store_len = POS_W'(PACKET_BYTES);
   assign rd_addr   = sum[AW-1:0];
   assign idle      = (state_ff == W_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         W_IDLE: begin
            if (start) state_in = W_REC;
         end
         W_REC: begin
            state_in = (left_ff == 16'd0) ? W_SUM : W_NAME_ISSUE;
         end
         W_NAME_ISSUE: begin
            state_in = beyond ? W_SUM : W_NAME_USE;
         end
         W_NAME_USE: begin
            if (pointer) state_in = W_PTR;
            else if (rd_data == 8'd0) state_in = W_FLD_ISSUE;
            else state_in = W_NAME_ISSUE;
         end
         W_PTR: begin
            state_in = beyond ? W_SUM : W_PTR_STEP;
         end
         W_PTR_STEP: begin
            state_in = W_FLD_ISSUE;
         end
         W_FLD_ISSUE: begin
            state_in = beyond ? W_SUM : W_FLD_USE;
         end
         W_FLD_USE: begin
            if (cnt_ff == FIELD_LAST) state_in = rec_match ? W_ADR_ISSUE : W_SKIP;
            else state_in = W_FLD_ISSUE;
         end
         W_ADR_ISSUE: begin
            state_in = beyond ? W_SUM : W_ADR_USE;
         end
         W_ADR_USE: begin
            state_in = (cnt_ff == ADDR_LAST) ? W_HIT : W_ADR_ISSUE;
         end
         W_HIT: begin
            if (!hit_room || emit_ready) state_in = W_SKIP;
         end
         W_SKIP: begin
            state_in = W_REC;
         end
         W_SUM: begin
            if (emit_ready) state_in = W_IDLE;
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   // Datapath updates, cursor control and result words.
   always_comb begin
      pos_in     = pos_ff;
      ulen_in    = ulen_ff;
      left_in    = left_ff;
      done_in    = done_ff;
      hits_in    = hits_ff;
      found_in   = found_ff;
      bad_in     = bad_ff;
      cnt_in     = cnt_ff;
      fld_in     = fld_ff;
      addr_in    = addr_ff;
      addend     = '0;
      emit_valid = 1'b0;
      emit_data  = '0;
      case (state_ff)
         W_IDLE: begin
            if (start) begin
               pos_in   = POS_W'(start_offset);
               ulen_in  = (resp_ext > store_len) ? ULEN_W'(PACKET_BYTES)
                                                  : ULEN_W'(response_length);
               left_in  = answer_count;
               done_in  = '0;
               hits_in  = '0;
               found_in = 1'b0;
               bad_in   = 1'b0;
            end
         end
         W_REC: begin
            cnt_in = '0;
         end
         W_NAME_ISSUE: begin
            if (beyond) bad_in = 1'b1;
         end
         W_NAME_USE: begin
            // A plain label (or the root byte) advances past itself and its text.
            if (!pointer) begin
               addend = ADDEND_W'(rd_data) + ADDEND_W'(1);
               pos_in = sum;
            end
         end
         W_PTR: begin
            // The second pointer byte is only checked, never followed.
            addend = ADDEND_W'(1);
            if (beyond) bad_in = 1'b1;
            else pos_in = sum;
         end
         W_PTR_STEP: begin
            addend = ADDEND_W'(1);
            pos_in = sum;
         end
         W_FLD_ISSUE: begin
            addend = ADDEND_W'(cnt_ff);
            if (beyond) bad_in = 1'b1;
         end
         W_FLD_USE: begin
            fld_in = fld_next;
            cnt_in = cnt_ff + BYTE_CNT_W'(1);
         end
         W_ADR_ISSUE: begin
            addend = ADDEND_W'(cnt_ff);
            if (beyond) bad_in = 1'b1;
         end
         W_ADR_USE: begin
            addr_in = {addr_ff[23:0], rd_data};
            cnt_in  = cnt_ff + BYTE_CNT_W'(1);
         end
         W_HIT: begin
            found_in   = 1'b1;
            emit_valid = hit_room;
            emit_data.result_kind   = RESULT_ADDR;
            emit_data.ipv4_address  = addr_ff;
            emit_data.time_to_live  = fld_ff[47:16];
            emit_data.record_number = done_ff;
            emit_data.found_any     = 1'b1;
            if (hit_room && emit_ready) hits_in = hits_ff + HIT_CNT_W'(1);
         end
         W_SKIP: begin
            // Step over the fixed fields and the record data.
            addend  = ADDEND_W'(fld_ff[15:0]) + ADDEND_W'(FIELD_BYTES);
            pos_in  = sum;
            left_in = left_ff - 16'd1;
            done_in = done_ff + 16'd1;
         end
         W_SUM: begin
            emit_valid = 1'b1;
            emit_data.result_kind   = RESULT_SUMMARY;
            emit_data.record_number = done_ff;
            emit_data.found_any     = found_ff;
            emit_data.malformed     = bad_ff;
            emit_data.last          = 1'b1;
         end
         default: begin
            addend = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= W_IDLE;
         pos_ff   <= '0;
         ulen_ff  <= '0;
         left_ff  <= '0;
         done_ff  <= '0;
         hits_ff  <= '0;
         found_ff <= 1'b0;
         bad_ff   <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         ulen_ff  <= ulen_in;
         left_ff  <= left_in;
         done_ff  <= done_in;
         hits_ff  <= hits_in;
         found_ff <= found_in;
         bad_ff   <= bad_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      fld_ff  <= fld_in;
      addr_ff <= addr_in;
   end

endmodule
